// ===== sv/assert_macros.svh =====
// ------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the link handshake checkers
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define RLH_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// same-cycle implication
`define RLH_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RLH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/rlh_pkg.sv =====
// ------------------------------------------------------------------------
// rlh_pkg
// types and constants shared by the link handshake modules
// ------------------------------------------------------------------------
package rlh_pkg;

	typedef enum logic [2:0] {
		PH_DISC      = 3'd0,
		PH_INIT      = 3'd1,
		PH_LISTEN    = 3'd2,
		PH_CONNECT   = 3'd3,
		PH_CONNECTED = 3'd4,
		PH_CHECK     = 3'd5,
		PH_REPLY     = 3'd6,
		PH_PINGED    = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		MT_INIT  = 2'd0,
		MT_PING  = 2'd1,
		MT_PONG  = 2'd2,
		MT_OTHER = 2'd3
	} msg_type_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_MASTER = 2'd1,
		EV_SLAVE  = 2'd2
	} conn_event_t;

	typedef enum logic [1:0] {
		CFG_ACK_TIMEOUT     = 2'd0,
		CFG_OK_TIMEOUT      = 2'd1,
		CFG_PING_INTERVAL   = 2'd2,
		CFG_PING_MISS_LIMIT = 2'd3
	} cfg_index_t;

	localparam int CFG_DATA_W = 16;

	// control frame payloads
	localparam logic [15:0] CONN_PAYLOAD = 16'h51A4;
	localparam logic [15:0] ACK_PAYLOAD  = 16'hAC40;
	localparam logic [15:0] OK_PAYLOAD   = 16'hC055;

	// register reset values and the miss counter ceiling
	localparam logic [15:0] ACK_TIMEOUT_RST   = 16'd500;
	localparam logic [15:0] OK_TIMEOUT_RST    = 16'd500;
	localparam logic [15:0] PING_INTERVAL_RST = 16'd2000;
	localparam logic [7:0]  PING_MISS_RST     = 8'd3;
	localparam logic [7:0]  MISS_MAX          = 8'hFF;

	typedef struct packed {
		logic [15:0] ack_timeout_ms;
		logic [15:0] ok_timeout_ms;
		logic [15:0] ping_interval_ms;
		logic [7:0]  ping_miss_limit;
	} cfg_t;

	typedef struct packed {
		logic        arrival;
		logic        droppable;
		logic [31:0] now_ms;
		msg_type_t   msg_type;
		logic [31:0] msg_payload;
		logic [11:0] listen_draw;
	} item_t;

	typedef struct packed {
		logic        tx_valid;
		msg_type_t   tx_type;
		logic [31:0] tx_payload;
		phase_t      link_state;
		logic        role;
		conn_event_t connect_event;
		logic        show_valid;
		logic [31:0] show_payload;
	} result_t;

endpackage

// ===== sv/radio_link_handshake_fsm_unit.sv =====
// ------------------------------------------------------------------------
// radio_link_handshake_fsm_unit
// peer link handshake: role negotiation, keep-alive and message buffering
// ------------------------------------------------------------------------
// usage
//  input channel: a transaction is taken on a clock edge with push high and
//   full low; mode selects a poll step or a message arrival, and every
//   transaction carries the current millisecond time
//  result channel: while empty is low the oldest result sits on the result
//   ports; it is taken on an edge with pop high; each input gives one result
//  configuration: cfg_wr_en, cfg_index and cfg_data write one register per
//   edge; the user must write only while no transaction is in flight, since
//   the block itself does not enforce it
//  path: a taken transaction is held in the input queue, the combinational
//   engine steps it and the result is stored in the result queue for pop
//  throughput: one transaction per cycle while the result queue has room;
//   the input and result queues let either side stall on its own
//  stall: when the consumer stops popping the result queue fills, the engine
//   holds and then the input queue fills and raises full
//  reset: asynchronous, active low; both queues empty, link disconnected,
//   role master, registers back to their reset values
// ------------------------------------------------------------------------
module radio_link_handshake_fsm_unit import rlh_pkg::*; #(
	parameter int IN_DEPTH  = 2,
	parameter int OUT_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_wr_en,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input queue side
	input  logic                  push,
	output logic                  full,
	input  logic                  mode,
	input  logic [31:0]           now_ms,
	input  logic [1:0]            msg_type,
	input  logic [31:0]           msg_payload,
	input  logic [11:0]           listen_draw,
	// result queue side
	output logic                  empty,
	input  logic                  pop,
	output logic                  tx_valid,
	output logic [1:0]            tx_type,
	output logic [31:0]           tx_payload,
	output logic [2:0]            link_state,
	output logic                  role,
	output logic [1:0]            connect_event,
	output logic                  show_valid,
	output logic [31:0]           show_payload
);

	cfg_t    cfg_q;
	logic    item_valid;
	item_t   item;
	logic    take;
	logic    res_valid;
	logic    res_full;
	result_t res;
	result_t head;

	// configuration registers, written directly by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ack_timeout_ms   <= ACK_TIMEOUT_RST;
			cfg_q.ok_timeout_ms    <= OK_TIMEOUT_RST;
			cfg_q.ping_interval_ms <= PING_INTERVAL_RST;
			cfg_q.ping_miss_limit  <= PING_MISS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index_t'(cfg_index))
				CFG_ACK_TIMEOUT:     cfg_q.ack_timeout_ms   <= cfg_data;
				CFG_OK_TIMEOUT:      cfg_q.ok_timeout_ms    <= cfg_data;
				CFG_PING_INTERVAL:   cfg_q.ping_interval_ms <= cfg_data;
				CFG_PING_MISS_LIMIT: cfg_q.ping_miss_limit  <= cfg_data[7:0];
				default:             cfg_q                  <= cfg_q;
			endcase
		end
	end

	// front: accept and tag transactions
	rlh_front #(
		.DEPTH(IN_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.mode       (mode),
		.now_ms     (now_ms),
		.msg_type   (msg_type),
		.msg_payload(msg_payload),
		.listen_draw(listen_draw),
		.full       (full),
		.item_valid (item_valid),
		.item       (item),
		.take       (take)
	);

	// back: the handshake state machine
	rlh_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item_valid(item_valid),
		.item      (item),
		.take      (take),
		.res_full  (res_full),
		.res_valid (res_valid),
		.res       (res)
	);

	// results wait here for the consumer
	rlh_outq #(
		.DEPTH(OUT_DEPTH)
	) u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_valid),
		.din   (res),
		.full  (res_full),
		.empty (empty),
		.pop   (pop),
		.dout  (head)
	);

	// unpack the head of the result queue
	assign tx_valid      = head.tx_valid;
	assign tx_type       = head.tx_type;
	assign tx_payload    = head.tx_payload;
	assign link_state    = head.link_state;
	assign role          = head.role;
	assign connect_event = head.connect_event;
	assign show_valid    = head.show_valid;
	assign show_payload  = head.show_payload;

endmodule

// ===== sv/rlh_front.sv =====
// ------------------------------------------------------------------------
// rlh_front
// input queue: accepts transactions, tags them and holds them for the engine
// ------------------------------------------------------------------------
module rlh_front import rlh_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        mode,
	input  logic [31:0] now_ms,
	input  logic [1:0]  msg_type,
	input  logic [31:0] msg_payload,
	input  logic [11:0] listen_draw,
	output logic        full,
	output logic        item_valid,
	output item_t       item,
	input  logic        take
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t             entry_q [DEPTH];
	logic [IDX_W-1:0]  wr_ptr_q;
	logic [IDX_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;
	item_t             cls_item;

	function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
		logic [IDX_W-1:0] r;
		if (p == IDX_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + IDX_W'(1);
		end
		return r;
	endfunction

	// classification
	always_comb begin
		cls_item.arrival     = mode;
		cls_item.droppable   = (msg_type_t'(msg_type) == MT_PING) ||
		                       (msg_type_t'(msg_type) == MT_PONG);
		cls_item.now_ms      = now_ms;
		cls_item.msg_type    = msg_type_t'(msg_type);
		cls_item.msg_payload = msg_payload;
		cls_item.listen_draw = listen_draw;
	end

	assign full       = (count_q == CNT_W'(DEPTH));
	assign item_valid = (count_q != '0);
	assign item       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = take && item_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= cls_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!do_push && do_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== sv/rlh_engine.sv =====
// ------------------------------------------------------------------------
// rlh_engine
// handshake state machine: while the result queue has room, one queued transaction is carried out per cycle
// ------------------------------------------------------------------------
module rlh_engine import rlh_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    item_valid,
	input  item_t   item,
	output logic    take,
	input  logic    res_full,
	output logic    res_valid,
	output result_t res
);

	phase_t      phase_q, phase_d;
	logic        role_q, role_d;
	logic [31:0] entry_q, entry_d;
	logic [11:0] win_q, win_d;
	logic [7:0]  miss_q, miss_d;
	logic        hv_q, hv_d;
	msg_type_t   ht_q, ht_d;
	logic [31:0] hp_q, hp_d;

	logic [31:0] elapsed;
	logic        held_ctrl;
	logic        is_ack;
	logic        is_conn;
	logic        is_ok;
	logic        held_moves;
	logic        ack_late;
	logic        ok_late;
	logic        win_late;
	logic        ping_due;
	logic        miss_over;

	assign take      = item_valid && !res_full;
	assign res_valid = take;

	assign elapsed    = item.now_ms - entry_q;
	assign held_ctrl  = hv_q && (ht_q == MT_INIT) && (hp_q[31:16] == 16'h0000);
	assign is_ack     = held_ctrl && (hp_q[15:0] == ACK_PAYLOAD);
	assign is_conn    = held_ctrl && (hp_q[15:0] == CONN_PAYLOAD);
	assign is_ok      = held_ctrl && (hp_q[15:0] == OK_PAYLOAD);
	assign held_moves = hv_q && ((ht_q == MT_PING) || (ht_q == MT_PONG) || is_conn);
	assign ack_late   = elapsed > {16'h0000, cfg.ack_timeout_ms};
	assign ok_late    = elapsed > {16'h0000, cfg.ok_timeout_ms};
	assign win_late   = elapsed > {20'h00000, win_q};
	assign ping_due   = elapsed > {16'h0000, cfg.ping_interval_ms};
	assign miss_over  = miss_q > cfg.ping_miss_limit;

	// next state
	always_comb begin
		phase_d = phase_q;
		role_d  = role_q;
		entry_d = entry_q;
		win_d   = win_q;
		miss_d  = miss_q;
		hv_d    = hv_q;
		ht_d    = ht_q;
		hp_d    = hp_q;
		if (item.arrival) begin
			if (!hv_q) begin
				hv_d = 1'b1;
				ht_d = item.msg_type;
				hp_d = item.msg_payload;
			end else if (!item.droppable) begin
				ht_d = item.msg_type;
				hp_d = item.msg_payload;
			end
		end else begin
			case (phase_q)
				PH_DISC: begin
					phase_d = PH_INIT;
					entry_d = item.now_ms;
				end
				PH_INIT: begin
					if (is_ack) begin
						hv_d    = 1'b0;
						role_d  = 1'b0;
						phase_d = PH_CONNECTED;
						entry_d = item.now_ms;
					end else if (ack_late) begin
						win_d   = item.listen_draw;
						phase_d = PH_LISTEN;
						entry_d = item.now_ms;
					end
				end
				PH_LISTEN: begin
					// a fresh entry time never beats the window
					if (is_conn) begin
						hv_d    = 1'b0;
						phase_d = PH_CONNECT;
						entry_d = item.now_ms;
					end else if (win_late) begin
						phase_d = PH_DISC;
						entry_d = item.now_ms;
					end
				end
				PH_CONNECT: begin
					if (is_ok) begin
						hv_d    = 1'b0;
						role_d  = 1'b1;
						phase_d = PH_CONNECTED;
						entry_d = item.now_ms;
					end else if (ok_late) begin
						phase_d = PH_LISTEN;
						entry_d = item.now_ms;
					end
				end
				PH_CONNECTED: begin
					if (hv_q) begin
						if (ht_q == MT_PING) begin
							phase_d = PH_PINGED;
						end else if (ht_q == MT_PONG) begin
							phase_d = PH_REPLY;
						end else if (is_conn) begin
							phase_d = PH_LISTEN;
						end else begin
							hv_d = 1'b0;
						end
					end
					if (held_moves) begin
						entry_d = item.now_ms;
					end
					if (!role_q && !held_moves && ping_due) begin
						phase_d = PH_CHECK;
						entry_d = item.now_ms;
					end
					if (miss_over) begin
						miss_d  = '0;
						phase_d = PH_DISC;
						entry_d = item.now_ms;
					end
				end
				PH_CHECK: begin
					ht_d = MT_PING;
					hp_d = item.now_ms;
					if (miss_q != MISS_MAX) begin
						miss_d = miss_q + 8'd1;
					end
					phase_d = PH_CONNECTED;
					entry_d = item.now_ms;
				end
				PH_REPLY: begin
					if (hv_q && (ht_q == MT_PONG)) begin
						hv_d = 1'b0;
					end
					miss_d  = '0;
					phase_d = PH_CONNECTED;
					entry_d = item.now_ms;
				end
				PH_PINGED: begin
					if (hv_q && (ht_q == MT_PING)) begin
						ht_d = MT_PONG;
						hv_d = 1'b0;
					end
					phase_d = PH_CONNECTED;
					entry_d = item.now_ms;
				end
				default: begin
					phase_d = PH_DISC;
				end
			endcase
		end
	end

	// result
	always_comb begin
		res.tx_valid      = 1'b0;
		res.tx_type       = MT_INIT;
		res.tx_payload    = '0;
		res.link_state    = phase_d;
		res.role          = role_d;
		res.connect_event = EV_NONE;
		res.show_valid    = 1'b0;
		res.show_payload  = '0;
		if (!item.arrival) begin
			case (phase_q)
				PH_DISC: begin
					res.tx_valid   = 1'b1;
					res.tx_payload = {16'h0000, CONN_PAYLOAD};
				end
				PH_INIT: begin
					if (is_ack) begin
						res.tx_valid      = 1'b1;
						res.tx_payload    = {16'h0000, OK_PAYLOAD};
						res.connect_event = EV_MASTER;
					end
				end
				PH_LISTEN: begin
					if (is_conn) begin
						res.tx_valid   = 1'b1;
						res.tx_payload = {16'h0000, ACK_PAYLOAD};
					end
				end
				PH_CONNECT: begin
					if (is_ok) begin
						res.connect_event = EV_SLAVE;
					end
				end
				PH_CONNECTED: begin
					if (hv_q && !held_moves) begin
						res.show_valid   = 1'b1;
						res.show_payload = hp_q;
					end
				end
				PH_CHECK: begin
					res.tx_valid   = 1'b1;
					res.tx_type    = MT_PING;
					res.tx_payload = item.now_ms;
				end
				PH_PINGED: begin
					if (hv_q && (ht_q == MT_PING)) begin
						res.tx_valid   = 1'b1;
						res.tx_type    = MT_PONG;
						res.tx_payload = hp_q;
					end
				end
				default: begin
					res.tx_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DISC;
			role_q  <= 1'b0;
			entry_q <= '0;
			win_q   <= '0;
			miss_q  <= '0;
			hv_q    <= 1'b0;
			ht_q    <= MT_INIT;
			hp_q    <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			role_q  <= role_d;
			entry_q <= entry_d;
			win_q   <= win_d;
			miss_q  <= miss_d;
			hv_q    <= hv_d;
			ht_q    <= ht_d;
			hp_q    <= hp_d;
		end
	end

endmodule

// ===== sv/rlh_outq.sv =====
// ------------------------------------------------------------------------
// rlh_outq
// result queue between the engine and the consumer
// ------------------------------------------------------------------------
module rlh_outq import rlh_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t din,
	output logic    full,
	output logic    empty,
	input  logic    pop,
	output result_t dout
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	result_t          slot_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
		logic [IDX_W-1:0] r;
		if (p == IDX_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + IDX_W'(1);
		end
		return r;
	endfunction

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign dout    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!do_push && do_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== sv/rlh_checker.sv =====
// ------------------------------------------------------------------------
// rlh_checker
// port-level checks on the link handshake results
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module rlh_checker import rlh_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        tx_valid,
	input logic [1:0]  tx_type,
	input logic [31:0] tx_payload,
	input logic [2:0]  link_state,
	input logic        role,
	input logic [1:0]  connect_event,
	input logic        show_valid,
	input logic [31:0] show_payload
);

	`RLH_ASSERT_IMPLY(a_tx_idle_zero, clk, arst_n,
		!empty && !tx_valid,
		(tx_type == MT_INIT) && (tx_payload == 32'h0),
		"idle frame fields not zero")

	`RLH_ASSERT_IMPLY(a_master_event, clk, arst_n,
		!empty && (connect_event == EV_MASTER),
		tx_valid && (tx_payload == {16'h0000, OK_PAYLOAD}) &&
		(link_state == PH_CONNECTED) && !role,
		"master connect without ok frame")

	`RLH_ASSERT_IMPLY(a_slave_event, clk, arst_n,
		!empty && (connect_event == EV_SLAVE),
		!tx_valid && (link_state == PH_CONNECTED) && role,
		"slave connect in wrong state")

	`RLH_ASSERT_IMPLY(a_show_alone, clk, arst_n,
		!empty && show_valid,
		!tx_valid && (connect_event == EV_NONE),
		"shown message alongside frame or event")

	`RLH_ASSERT_NEXT(a_result_hold, clk, arst_n,
		!empty && !pop,
		!empty && $stable(tx_payload) && $stable(show_payload) && $stable(link_state),
		"stalled result changed")

endmodule

bind radio_link_handshake_fsm_unit rlh_checker u_rlh_checker (.*);

// ===== dv/testbench.sv =====
// ------------------------------------------------------------------------
// testbench
// drives poll and arrival transactions into the link handshake unit,
// predicts every result with its own model of the handshake state machine
// and checks the results field by field in the order they leave the block
// ------------------------------------------------------------------------
module testbench import rlh_pkg::*;;

	localparam int CYCLE_LIMIT = 100000;

	// one input transaction as planned by the stimulus
	typedef struct {
		logic        md;
		logic [31:0] now;
		logic [1:0]  mt;
		logic [31:0] mp;
		logic [11:0] dr;
		bit          drain_first;  // sender waits for all results before offering it
	} link_item_t;

	// handshake state as the prediction sees it
	typedef struct packed {
		phase_t      ph;
		logic        role;
		logic [31:0] entry;
		logic [11:0] win;
		logic [7:0]  misses;
		logic        held_v;
		logic [1:0]  held_ty;
		logic [31:0] held_pay;
	} link_ctx_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [1:0]            cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  push = 1'b0;
	logic                  full;
	logic                  mode = 1'b0;
	logic [31:0]           now_ms = '0;
	logic [1:0]            msg_type = '0;
	logic [31:0]           msg_payload = '0;
	logic [11:0]           listen_draw = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic                  tx_valid;
	logic [1:0]            tx_type;
	logic [31:0]           tx_payload;
	logic [2:0]            link_state;
	logic                  role;
	logic [1:0]            connect_event;
	logic                  show_valid;
	logic [31:0]           show_payload;

	// predicted copy of the registers, reset values to begin with
	logic [15:0] cfg_ack_ms   = ACK_TIMEOUT_RST;
	logic [15:0] cfg_ok_ms    = OK_TIMEOUT_RST;
	logic [15:0] cfg_ping_ms  = PING_INTERVAL_RST;
	logic [7:0]  cfg_miss_lim = PING_MISS_RST;

	link_ctx_t   lk = '0;
	link_item_t  queued_steps[$];
	result_t     predicted_results[$];
	logic [31:0] t_ms = '0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	bit          step_taken = 1'b0;
	int          results_checked = 0;
	int          fail_count = 0;
	int          cycle_count = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;

	// ---------------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------------
	function automatic logic [31:0] since_entry(input logic [31:0] now);
		return now - lk.entry;
	endfunction

	function automatic void enter_phase(input phase_t p, input logic [31:0] now);
		lk.ph = p;
		lk.entry = now;
	endfunction

	// held message is a control frame carrying this code
	function automatic bit holds_ctl(input logic [15:0] code);
		return lk.held_v && lk.held_ty == MT_INIT && lk.held_pay == {16'h0, code};
	endfunction

	// one poll or arrival; later assignments in a poll win, as in the block
	function automatic result_t step_link(input logic md, input logic [31:0] now,
			input logic [1:0] mt, input logic [31:0] mp, input logic [11:0] dr);
		result_t r;
		r = '0;
		if (md) begin
			// one-entry buffer: when full, ping and pong are dropped, others overwrite
			if (!lk.held_v) begin
				lk.held_v = 1'b1;
				lk.held_ty = mt;
				lk.held_pay = mp;
			end else if (mt != MT_PING && mt != MT_PONG) begin
				lk.held_ty = mt;
				lk.held_pay = mp;
			end
		end else begin
			case (lk.ph)
				PH_DISC: begin
					r.tx_valid = 1'b1; r.tx_type = MT_INIT; r.tx_payload = {16'h0, CONN_PAYLOAD};
					enter_phase(PH_INIT, now);
				end
				PH_INIT: begin
					if (holds_ctl(ACK_PAYLOAD)) begin
						lk.held_v = 1'b0;
						r.tx_valid = 1'b1; r.tx_type = MT_INIT; r.tx_payload = {16'h0, OK_PAYLOAD};
						lk.role = 1'b0;
						enter_phase(PH_CONNECTED, now);
						r.connect_event = EV_MASTER;
					end else if (since_entry(now) > cfg_ack_ms) begin
						lk.win = dr;
						enter_phase(PH_LISTEN, now);
					end
				end
				PH_LISTEN: begin
					if (holds_ctl(CONN_PAYLOAD)) begin
						lk.held_v = 1'b0;
						r.tx_valid = 1'b1; r.tx_type = MT_INIT; r.tx_payload = {16'h0, ACK_PAYLOAD};
						enter_phase(PH_CONNECT, now);
					end
					if (since_entry(now) > lk.win)
						enter_phase(PH_DISC, now);
				end
				PH_CONNECT: begin
					if (holds_ctl(OK_PAYLOAD)) begin
						lk.held_v = 1'b0;
						lk.role = 1'b1;
						enter_phase(PH_CONNECTED, now);
						r.connect_event = EV_SLAVE;
					end else if (since_entry(now) > cfg_ok_ms) begin
						enter_phase(PH_LISTEN, now);
					end
				end
				PH_CONNECTED: begin
					if (lk.held_v) begin
						if (lk.held_ty == MT_PING) begin
							enter_phase(PH_PINGED, now);
						end else if (lk.held_ty == MT_PONG) begin
							enter_phase(PH_REPLY, now);
						end else if (holds_ctl(CONN_PAYLOAD)) begin
							enter_phase(PH_LISTEN, now);
						end else begin
							r.show_valid = 1'b1;
							r.show_payload = lk.held_pay;
							lk.held_v = 1'b0;
						end
					end
					if (!lk.role && since_entry(now) > cfg_ping_ms)
						enter_phase(PH_CHECK, now);
					if (lk.misses > cfg_miss_lim) begin
						lk.misses = '0;
						enter_phase(PH_DISC, now);
					end
				end
				PH_CHECK: begin
					// the outgoing ping lands in the buffer, its valid bit untouched
					lk.held_ty = MT_PING;
					lk.held_pay = now;
					r.tx_valid = 1'b1; r.tx_type = MT_PING; r.tx_payload = now;
					if (lk.misses < MISS_MAX)
						lk.misses = lk.misses + 8'd1;
					enter_phase(PH_CONNECTED, now);
				end
				PH_REPLY: begin
					if (lk.held_v && lk.held_ty == MT_PONG)
						lk.held_v = 1'b0;
					lk.misses = '0;
					enter_phase(PH_CONNECTED, now);
				end
				PH_PINGED: begin
					if (lk.held_v && lk.held_ty == MT_PING) begin
						lk.held_ty = MT_PONG;
						r.tx_valid = 1'b1; r.tx_type = MT_PONG; r.tx_payload = lk.held_pay;
						lk.held_v = 1'b0;
					end
					enter_phase(PH_CONNECTED, now);
				end
				default: ;
			endcase
		end
		r.link_state = lk.ph;
		r.role = lk.role;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// stimulus planning
	// ---------------------------------------------------------------------
	function automatic logic [31:0] pick_payload();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		return $urandom;
	endfunction

	task automatic plan_item(input logic md, input logic [1:0] mt, input logic [31:0] mp,
			input logic [11:0] dr, input bit drain_first);
		link_item_t it;
		it.md = md;
		it.now = t_ms;
		it.mt = mt;
		it.mp = mp;
		it.dr = dr;
		it.drain_first = drain_first;
		queued_steps.push_back(it);
	endtask

	// state-aware sequences: a shadow run of the prediction picks each next
	// transaction so that handshakes complete; storm steers to master and then
	// lets pings go unanswered
	task automatic plan_random(input int count, input bit storm);
		link_ctx_t   saved;
		logic        md;
		logic [1:0]  mt;
		logic [31:0] mp;
		logic [11:0] dr;
		int          roll;
		saved = lk;
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			md = 1'b0;
			mt = MT_INIT;
			mp = pick_payload();
			dr = 12'($urandom_range(1000, 3999));
			t_ms += $urandom_range(0, 40);
			if (!storm && roll < 8) begin
				// noise: anything the fields allow, sometimes a jump in time
				md = 1'($urandom_range(0, 1));
				mt = 2'($urandom_range(0, 3));
				dr = 12'($urandom_range(0, 4095));
				if (roll < 2)
					t_ms = $urandom;
			end else begin
				roll = $urandom_range(0, 99);
				case (lk.ph)
					PH_INIT: begin
						if (!holds_ctl(ACK_PAYLOAD)) begin
							if (storm || roll < 55) begin
								md = 1'b1; mp = {16'h0, ACK_PAYLOAD};
							end else begin
								t_ms = lk.entry + cfg_ack_ms + $urandom_range(0, 2);
							end
						end
					end
					PH_LISTEN: begin
						if (!holds_ctl(CONN_PAYLOAD)) begin
							if (!storm && roll < 55) begin
								md = 1'b1; mp = {16'h0, CONN_PAYLOAD};
							end else begin
								t_ms = lk.entry + lk.win + $urandom_range(0, 2);
							end
						end
					end
					PH_CONNECT: begin
						if (!holds_ctl(OK_PAYLOAD)) begin
							if (!storm && roll < 55) begin
								md = 1'b1; mp = {16'h0, OK_PAYLOAD};
							end else begin
								t_ms = lk.entry + cfg_ok_ms + $urandom_range(0, 2);
							end
						end
					end
					PH_CONNECTED: begin
						if (storm) begin
							if (lk.role && !holds_ctl(CONN_PAYLOAD)) begin
								md = 1'b1; mp = {16'h0, CONN_PAYLOAD};
							end else if (!lk.role) begin
								t_ms = lk.entry + cfg_ping_ms + 1;
							end
						end else if (roll < 14) begin
							md = 1'b1; mt = MT_PING;
						end else if (roll < 28) begin
							md = 1'b1; mt = MT_PONG;
						end else if (roll < 42) begin
							md = 1'b1; mt = MT_OTHER;
						end else if (roll < 48) begin
							md = 1'b1;
						end else if (roll < 53) begin
							md = 1'b1; mp = {16'h0, CONN_PAYLOAD};
						end else if (roll < 75) begin
							t_ms = lk.entry + cfg_ping_ms + $urandom_range(0, 2);
						end
					end
					default: begin
						// disconnected and the one-step phases mostly just poll
						if (!storm && roll < 20) begin
							md = 1'b1; mt = 2'($urandom_range(0, 3));
						end
					end
				endcase
			end
			plan_item(md, mt, mp, dr, k == count / 2);
			void'(step_link(md, t_ms, mt, mp, dr));
		end
		lk = saved;
	endtask

	// register write, mirrored into the prediction
	task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_ACK_TIMEOUT:     cfg_ack_ms = data;
			CFG_OK_TIMEOUT:      cfg_ok_ms = data;
			CFG_PING_INTERVAL:   cfg_ping_ms = data;
			CFG_PING_MISS_LIMIT: cfg_miss_lim = data[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// returns at a falling edge once nothing is queued, offered or predicted
	task automatic wait_idle();
		bit quiet;
		quiet = 1'b0;
		while (!quiet) begin
			@(posedge clk);
			quiet = queued_steps.size() == 0 && !push;
			@(negedge clk);
			quiet = quiet && predicted_results.size() == 0;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s expected %0h got %0h", name, want, got);
			fail_count++;
		end
	endtask

	// ---------------------------------------------------------------------
	// block under test
	// ---------------------------------------------------------------------
	radio_link_handshake_fsm_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.mode          (mode),
		.now_ms        (now_ms),
		.msg_type      (msg_type),
		.msg_payload   (msg_payload),
		.listen_draw   (listen_draw),
		.empty         (empty),
		.pop           (pop),
		.tx_valid      (tx_valid),
		.tx_type       (tx_type),
		.tx_payload    (tx_payload),
		.link_state    (link_state),
		.role          (role),
		.connect_event (connect_event),
		.show_valid    (show_valid),
		.show_payload  (show_payload)
	);

	always #2 clk = ~clk;

	// run-away guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("radio_link_handshake_fsm_unit verification failed");
			$finish;
		end
	end

	// sender: a new transaction goes out once the last one was taken or none
	// was on offer; an item marked drain_first waits for every result
	always @(negedge clk) begin
		link_item_t it;
		if (!push || step_taken) begin
			step_taken = 1'b0;
			if (queued_steps.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct
					&& !(queued_steps[0].drain_first && predicted_results.size() != 0)) begin
				it = queued_steps.pop_front();
				push <= 1'b1;
				mode <= it.md;
				now_ms <= it.now;
				msg_type <= it.mt;
				msg_payload <= it.mp;
				listen_draw <= it.dr;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver: random pops, plus one long hold-off so the block backs up
	// all the way to full
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			pop <= 1'b0;
		end else if (!hold_done && results_checked >= 150) begin
			hold_done <= 1'b1;
			hold_left <= 400;
			pop <= 1'b0;
		end else begin
			pop <= $urandom_range(0, 99) >= rx_idle_pct;
		end
	end

	// monitor: results are checked before the prediction of a transaction
	// taken on the same edge is queued
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (predicted_results.size() == 0) begin
					$error("result transaction with no prediction waiting");
					fail_count++;
				end else begin
					want = predicted_results.pop_front();
					check_field("tx_valid", want.tx_valid, tx_valid);
					check_field("tx_type", want.tx_type, tx_type);
					check_field("tx_payload", want.tx_payload, tx_payload);
					check_field("link_state", want.link_state, link_state);
					check_field("role", want.role, role);
					check_field("connect_event", want.connect_event, connect_event);
					check_field("show_valid", want.show_valid, show_valid);
					check_field("show_payload", want.show_payload, show_payload);
				end
				results_checked++;
			end
			if (push && !full) begin
				predicted_results.push_back(step_link(mode, now_ms, msg_type, msg_payload,
						listen_draw));
				step_taken = 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------------
	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// directed walk through every phase but the ping check, with reset register values
		@(posedge clk);
		tx_idle_pct = 32;
		rx_idle_pct = 62;
		t_ms = '0;
		plan_item(1'b1, MT_OTHER, 32'hFFFF_FFFF, 12'd2000, 1'b0);  // fills the buffer
		plan_item(1'b1, MT_PING, 32'h0, 12'd2000, 1'b0);           // dropped, buffer full
		plan_item(1'b1, MT_PONG, 32'h1234, 12'd2000, 1'b0);        // dropped, buffer full
		plan_item(1'b1, MT_INIT, 32'h0, 12'd2000, 1'b0);           // overwrites
		t_ms = 32'hFFFF_FFFF;
		plan_item(1'b0, MT_INIT, 32'h0, 12'd2000, 1'b0);           // broadcast
		t_ms += 500;                                                // wraps, not yet timed out
		plan_item(1'b0, MT_INIT, 32'h0, 12'd2000, 1'b0);
		t_ms += 1;                                                  // ack timeout, odd draw
		plan_item(1'b0, MT_INIT, 32'h0, 12'hFFF, 1'b0);
		plan_item(1'b1, MT_INIT, {16'h0, CONN_PAYLOAD}, 12'd0, 1'b0);
		t_ms += 10;
		plan_item(1'b0, MT_INIT, 32'h0, 12'd0, 1'b0);              // ack sent
		plan_item(1'b1, MT_INIT, {16'h0, OK_PAYLOAD}, 12'd0, 1'b0);
		t_ms += 10;
		plan_item(1'b0, MT_INIT, 32'h0, 12'd0, 1'b0);              // connected as slave
		plan_item(1'b1, MT_OTHER, 32'hFFFF_FFFF, 12'd0, 1'b0);
		plan_item(1'b0, MT_INIT, 32'h0, 12'd0, 1'b0);              // message shown
		plan_item(1'b1, MT_PING, 32'h0, 12'd0, 1'b0);
		plan_item(1'b0, MT_INIT, 32'h0, 12'd0, 1'b0);              // pinged
		plan_item(1'b0, MT_INIT, 32'h0, 12'd0, 1'b0);              // pong back
		plan_item(1'b1, MT_PONG, 32'h5A5A_0F0F, 12'd0, 1'b0);
		plan_item(1'b0, MT_INIT, 32'h0, 12'd0, 1'b0);              // reply
		plan_item(1'b0, MT_INIT, 32'h0, 12'd0, 1'b0);
		plan_item(1'b1, MT_INIT, {16'h0, CONN_PAYLOAD}, 12'd0, 1'b0);
		plan_item(1'b0, MT_INIT, 32'h0, 12'd1500, 1'b0);           // listen, old window kept
		t_ms += 4096;
		plan_item(1'b0, MT_INIT, 32'h0, 12'd1500, 1'b0);           // connect request still held, ack sent
		plan_item(1'b0, MT_INIT, 32'h0, 12'd1500, 1'b0);
		plan_item(1'b1, MT_INIT, {16'h0, ACK_PAYLOAD}, 12'd1500, 1'b0);
		plan_item(1'b0, MT_INIT, 32'h0, 12'd1500, 1'b0);           // held ack ignored, still connecting
		t_ms += 2001;
		plan_item(1'b0, MT_INIT, 32'h0, 12'd1500, 1'b0);           // ok timeout, back to listen
		plan_item(1'b0, MT_INIT, 32'h0, 12'd1500, 1'b0);           // still listening

		// all registers at their lowest, junk above the miss limit byte
		wait_idle();
		write_reg(CFG_ACK_TIMEOUT, 16'd0);
		write_reg(CFG_OK_TIMEOUT, 16'd0);
		write_reg(CFG_PING_INTERVAL, 16'd0);
		write_reg(CFG_PING_MISS_LIMIT, 16'hA500);
		@(posedge clk);
		plan_random(300, 1'b0);

		// all registers at their highest
		wait_idle();
		write_reg(CFG_ACK_TIMEOUT, 16'hFFFF);
		write_reg(CFG_OK_TIMEOUT, 16'hFFFF);
		write_reg(CFG_PING_INTERVAL, 16'hFFFF);
		write_reg(CFG_PING_MISS_LIMIT, 16'h00FF);
		@(posedge clk);
		tx_idle_pct = 62;
		rx_idle_pct = 32;
		plan_random(200, 1'b0);

		// unanswered pings until the miss counter sits at its ceiling
		wait_idle();
		write_reg(CFG_PING_INTERVAL, 16'd0);
		@(posedge clk);
		plan_random(560, 1'b1);

		// lowest miss limit drops the saturated link, then middling timings
		wait_idle();
		write_reg(CFG_PING_MISS_LIMIT, {8'($urandom), 8'd0});
		write_reg(CFG_ACK_TIMEOUT, 16'($urandom_range(0, 3000)));
		write_reg(CFG_OK_TIMEOUT, 16'($urandom_range(0, 3000)));
		write_reg(CFG_PING_INTERVAL, 16'($urandom_range(0, 5000)));
		@(posedge clk);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		plan_random(300, 1'b0);

		wait_idle();
		repeat (6) @(negedge clk);
		if (fail_count == 0)
			$display("radio_link_handshake_fsm_unit verification clean");
		else
			$display("radio_link_handshake_fsm_unit verification failed");
		$finish;
	end

endmodule
